// ----- rtl/bfs_pkg.sv -----
// Battery fault supervisor package: transaction types, configuration block and register indexes.
// No dependencies; imported by every module of the supervisor.
`default_nettype none

package bfs_pkg;

  localparam logic [7:0]  UV_CONSEC_SAMPLES = 8'd3;
  localparam logic [7:0]  TEMP_EVAL_PERIOD  = 8'd5;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_UV_MV,
    REG_UV_RECOVER_MV,
    REG_UV_RECOVER_TICKS,
    REG_OT_LIMIT,
    REG_OT_RECOVER_LIMIT,
    REG_OT_RECOVER_TICKS,
    REG_HEAT_ON_LIMIT,
    REG_HEAT_OFF_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [14:0]        volt_sample;
    logic               volt_valid;
    logic signed [15:0] temp_sample;
    logic               temp_valid;
    logic               heater_permitted;
  } in_item_t;

  typedef struct packed {
    logic undervolt_fault;
    logic overtemp_fault;
    logic cold_fault;
    logic heater_drive;
    logic undervolt_set_pulse;
    logic overtemp_set_pulse;
    logic cold_set_pulse;
    logic volt_sensor_reinit;
    logic temp_evaluated;
  } out_item_t;

  typedef struct packed {
    logic [14:0]        undervolt_mv;
    logic [14:0]        undervolt_recover_mv;
    logic [15:0]        undervolt_recover_ticks;
    logic signed [15:0] overtemp_limit;
    logic signed [15:0] overtemp_recover_limit;
    logic [15:0]        overtemp_recover_ticks;
    logic signed [15:0] heat_on_limit;
    logic signed [15:0] heat_off_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/battery_fault_supervisor.sv -----
// Battery fault supervisor top level: input register, tick update, result register.
// Depends on bfs_pkg, bfs_regs and bfs_core.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   in_data  (in_item_t)
//   out_      output     out_valid / out_stall out_data (out_item_t)
//   config    input      psel/penable/pwrite   paddr, pwdata, prdata (APB-style)
//
// One tick per cycle while out_stall is low; a tick's result passes through the input
// register, then the result register holding the updated state.
// Reset is synchronous, active low; it clears all fault state and restores the
// register defaults. A stalled result holds in the result register while one more
// transaction waits in the input register; in_stall rises only when both are full.
`default_nettype none

module battery_fault_supervisor
  import bfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t      cfg;
  in_item_t  s1_data_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t res;
  logic      s1_adv, s1_load, step;

  bfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign s1_adv       = ~out_valid_r | ~out_stall;
  assign step         = s1_valid_r & s1_adv;
  assign in_stall     = s1_valid_r & ~s1_adv;
  assign s1_load      = in_valid & ~in_stall;
  assign s1_valid_nxt = s1_load | (s1_valid_r & ~s1_adv);
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bfs_regs.sv -----
// Battery fault supervisor configuration registers behind an APB-style port.
// Depends on bfs_pkg for the register indexes and the configuration block type.
`default_nettype none

module bfs_regs
  import bfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.undervolt_mv            <= 15'd3300;
      cfg_r.undervolt_recover_mv    <= 15'd3500;
      cfg_r.undervolt_recover_ticks <= 16'd10;
      cfg_r.overtemp_limit          <= 16'sd4500;
      cfg_r.overtemp_recover_limit  <= 16'sd4000;
      cfg_r.overtemp_recover_ticks  <= 16'd60;
      cfg_r.heat_on_limit           <= 16'sd0;
      cfg_r.heat_off_limit          <= 16'sd500;
    end else if (wr_en) begin
      case (idx)
        REG_UV_MV:            cfg_r.undervolt_mv            <= pwdata[14:0];
        REG_UV_RECOVER_MV:    cfg_r.undervolt_recover_mv    <= pwdata[14:0];
        REG_UV_RECOVER_TICKS: cfg_r.undervolt_recover_ticks <= pwdata[15:0];
        REG_OT_LIMIT:         cfg_r.overtemp_limit          <= pwdata[15:0];
        REG_OT_RECOVER_LIMIT: cfg_r.overtemp_recover_limit  <= pwdata[15:0];
        REG_OT_RECOVER_TICKS: cfg_r.overtemp_recover_ticks  <= pwdata[15:0];
        REG_HEAT_ON_LIMIT:    cfg_r.heat_on_limit           <= pwdata[15:0];
        REG_HEAT_OFF_LIMIT:   cfg_r.heat_off_limit          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UV_MV:            prdata = {17'd0, cfg_r.undervolt_mv};
      REG_UV_RECOVER_MV:    prdata = {17'd0, cfg_r.undervolt_recover_mv};
      REG_UV_RECOVER_TICKS: prdata = {16'd0, cfg_r.undervolt_recover_ticks};
      REG_OT_LIMIT:         prdata = {16'd0, cfg_r.overtemp_limit};
      REG_OT_RECOVER_LIMIT: prdata = {16'd0, cfg_r.overtemp_recover_limit};
      REG_OT_RECOVER_TICKS: prdata = {16'd0, cfg_r.overtemp_recover_ticks};
      REG_HEAT_ON_LIMIT:    prdata = {16'd0, cfg_r.heat_on_limit};
      REG_HEAT_OFF_LIMIT:   prdata = {16'd0, cfg_r.heat_off_limit};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bfs_core.sv -----
// Battery fault supervisor tick update: fault flags, recovery counters, heater state.
// Depends on bfs_pkg for transaction types, configuration block and constants.
`default_nettype none

module bfs_core
  import bfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     res
);

  logic [7:0]  low_run_r, low_run_nxt;
  logic [15:0] uv_cnt_r, uv_cnt_nxt;
  logic [15:0] ot_cnt_r, ot_cnt_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic        uv_r, uv_nxt;
  logic        ot_r, ot_nxt;
  logic        cold_r, cold_nxt;
  logic        heat_r, heat_nxt;

  logic [7:0]  low_inc;
  logic [15:0] uv_inc;
  logic [16:0] ot_sum;
  logic [15:0] ot_inc;
  logic [7:0]  phase_inc;
  logic        eval;
  logic        uv_pulse, ot_pulse, cold_pulse;

  always_comb begin
    low_run_nxt = low_run_r;
    uv_cnt_nxt  = uv_cnt_r;
    ot_cnt_nxt  = ot_cnt_r;
    uv_nxt      = uv_r;
    ot_nxt      = ot_r;
    cold_nxt    = cold_r;
    heat_nxt    = heat_r;
    uv_pulse    = 1'b0;
    ot_pulse    = 1'b0;
    cold_pulse  = 1'b0;

    low_inc = (low_run_r < UV_CONSEC_SAMPLES) ? low_run_r + 8'd1 : low_run_r;
    uv_inc  = (uv_cnt_r < COUNT_MAX) ? uv_cnt_r + 16'd1 : uv_cnt_r;
    ot_sum  = {1'b0, ot_cnt_r} + {9'd0, TEMP_EVAL_PERIOD};
    ot_inc  = ot_sum[16] ? COUNT_MAX : ot_sum[15:0];

    if (item.volt_valid) begin
      if (item.volt_sample < cfg.undervolt_mv) begin
        low_run_nxt = low_inc;
        if (low_inc >= UV_CONSEC_SAMPLES) begin
          uv_pulse   = ~uv_r;
          uv_nxt     = 1'b1;
          uv_cnt_nxt = '0;
        end
      end else begin
        low_run_nxt = '0;
        if (uv_r) begin
          if (item.volt_sample >= cfg.undervolt_recover_mv) begin
            uv_cnt_nxt = uv_inc;
            if (uv_inc >= cfg.undervolt_recover_ticks) begin
              uv_nxt     = 1'b0;
              uv_cnt_nxt = '0;
            end
          end else begin
            uv_cnt_nxt = '0;
          end
        end
      end
    end

    phase_inc = phase_r + 8'd1;
    eval      = (phase_inc >= TEMP_EVAL_PERIOD);
    phase_nxt = eval ? 8'd0 : phase_inc;

    if (eval && item.temp_valid) begin
      if (item.temp_sample > cfg.overtemp_limit) begin
        ot_pulse   = ~ot_r;
        ot_nxt     = 1'b1;
        ot_cnt_nxt = '0;
      end else if (ot_r) begin
        if (item.temp_sample <= cfg.overtemp_recover_limit) begin
          ot_cnt_nxt = ot_inc;
          if (ot_inc >= cfg.overtemp_recover_ticks) begin
            ot_nxt     = 1'b0;
            ot_cnt_nxt = '0;
          end
        end else begin
          ot_cnt_nxt = '0;
        end
      end

      if (item.temp_sample < cfg.heat_on_limit) begin
        cold_pulse = ~cold_r;
        cold_nxt   = 1'b1;
        heat_nxt   = item.heater_permitted;
      end else if (item.temp_sample >= cfg.heat_off_limit) begin
        cold_nxt = 1'b0;
        heat_nxt = 1'b0;
      end else if (!item.heater_permitted) begin
        heat_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res.undervolt_fault     = uv_nxt;
    res.overtemp_fault      = ot_nxt;
    res.cold_fault          = cold_nxt;
    res.heater_drive        = heat_nxt;
    res.undervolt_set_pulse = uv_pulse;
    res.overtemp_set_pulse  = ot_pulse;
    res.cold_set_pulse      = cold_pulse;
    res.volt_sensor_reinit  = ~item.volt_valid;
    res.temp_evaluated      = eval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_run_r <= '0;
      uv_cnt_r  <= '0;
      ot_cnt_r  <= '0;
      phase_r   <= '0;
      uv_r      <= 1'b0;
      ot_r      <= 1'b0;
      cold_r    <= 1'b0;
      heat_r    <= 1'b0;
    end else if (step) begin
      low_run_r <= low_run_nxt;
      uv_cnt_r  <= uv_cnt_nxt;
      ot_cnt_r  <= ot_cnt_nxt;
      phase_r   <= phase_nxt;
      uv_r      <= uv_nxt;
      ot_r      <= ot_nxt;
      cold_r    <= cold_nxt;
      heat_r    <= heat_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bfs_checker.sv -----
// Battery fault supervisor port checker and its bind to the top level.
// Depends on bfs_pkg for the transaction types.
`default_nettype none

module bfs_checker
  import bfs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pulse_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.undervolt_set_pulse || out_data.undervolt_fault) &&
                  (!out_data.overtemp_set_pulse || out_data.overtemp_fault) &&
                  (!out_data.cold_set_pulse || out_data.cold_fault))
    else $error("set pulse without fault");

  a_heater_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.heater_drive |-> out_data.cold_fault)
    else $error("heater on without cold fault");

  a_temp_pulse_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.overtemp_set_pulse || out_data.cold_set_pulse) |->
      out_data.temp_evaluated && !(out_data.volt_sensor_reinit &&
                                   out_data.undervolt_set_pulse))
    else $error("temperature pulse off an evaluation tick");

endmodule

bind battery_fault_supervisor bfs_checker u_bfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for battery_fault_supervisor: directed table, then constrained-by-hand random ticks,
// every result checked against a typed table status or an in-bench fault/recovery/heater model.
// Depends on bfs_pkg and the supervisor RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfs_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int CHUNKS      = 5;
  localparam int CHUNK_TICKS = 110;
  localparam int DIR_ROWS    = 25;
  localparam int DIR_SPLIT   = 20;

  typedef struct packed {
    in_item_t  tick;
    logic      chk;
    out_item_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  battery_fault_supervisor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  int snd_idle = 35;
  int rcv_idle = 49;
  int mismatches = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  // supervisor mirror: limits and tick state
  cfg_t        limits;
  logic [7:0]  low_run = '0;
  logic [15:0] uv_recov = '0;
  logic [15:0] ot_recov = '0;
  logic [7:0]  eval_phase = '0;
  logic        uv_flag = 1'b0;
  logic        ot_flag = 1'b0;
  logic        cold_flag = 1'b0;
  logic        heater_on = 1'b0;

  out_item_t pending_status [$];

  int volt_mode = 0;
  int volt_left = 0;
  int temp_mode = 0;
  int temp_left = 0;

  // columns: volt, volt_valid, temp, temp_valid, permit, typed check, expected status
  dir_row_t dir_rows [DIR_ROWS] = '{
    {15'd32767, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 9'b000000000},
    {15'd0,     1'b1, 16'h8000, 1'b1, 1'b1, 1'b1, 9'b000000000},
    {15'd0,     1'b0, 16'h7FFF, 1'b0, 1'b0, 1'b1, 9'b000000010},
    {15'd0,     1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 9'b000000000},
    {15'd0,     1'b1, 16'h7FFF, 1'b1, 1'b1, 1'b1, 9'b110011001},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3499,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd32767, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3300,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 9'b0},
    {15'd3299,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b0, 1'b1, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'd499,  1'b1, 1'b0, 1'b0, 9'b0},
    {15'd0,     1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 9'b0},
    {15'd0,     1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 9'b0},
    {15'd0,     1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 9'b0},
    {15'd3500,  1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 9'b0}
  };

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function void report_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %b got %b", what, want, got);
  endfunction

  function automatic out_item_t next_status(input in_item_t it);
    out_item_t          st;
    logic signed [15:0] tc;
    logic [16:0]        ot_sum;
    st = '0;
    tc = it.temp_sample;
    if (it.volt_valid) begin
      if (it.volt_sample < limits.undervolt_mv) begin
        if (low_run < UV_CONSEC_SAMPLES) low_run = low_run + 8'd1;
        if (low_run >= UV_CONSEC_SAMPLES) begin
          st.undervolt_set_pulse = !uv_flag;
          uv_flag = 1'b1;
          uv_recov = '0;
        end
      end else begin
        low_run = '0;
        if (uv_flag) begin
          if (it.volt_sample >= limits.undervolt_recover_mv) begin
            if (uv_recov != COUNT_MAX) uv_recov = uv_recov + 16'd1;
            if (uv_recov >= limits.undervolt_recover_ticks) begin
              uv_flag = 1'b0;
              uv_recov = '0;
            end
          end else begin
            uv_recov = '0;
          end
        end
      end
    end
    eval_phase = eval_phase + 8'd1;
    if (eval_phase >= TEMP_EVAL_PERIOD) begin
      eval_phase = '0;
      st.temp_evaluated = 1'b1;
      if (it.temp_valid) begin
        if (tc > $signed(limits.overtemp_limit)) begin
          st.overtemp_set_pulse = !ot_flag;
          ot_flag = 1'b1;
          ot_recov = '0;
        end else if (ot_flag) begin
          if (tc <= $signed(limits.overtemp_recover_limit)) begin
            ot_sum = {1'b0, ot_recov} + 17'(TEMP_EVAL_PERIOD);
            ot_recov = ot_sum[16] ? COUNT_MAX : ot_sum[15:0];
            if (ot_recov >= limits.overtemp_recover_ticks) begin
              ot_flag = 1'b0;
              ot_recov = '0;
            end
          end else begin
            ot_recov = '0;
          end
        end
        if (tc < $signed(limits.heat_on_limit)) begin
          st.cold_set_pulse = !cold_flag;
          cold_flag = 1'b1;
          heater_on = it.heater_permitted;
        end else if (tc >= $signed(limits.heat_off_limit)) begin
          cold_flag = 1'b0;
          heater_on = 1'b0;
        end else if (!it.heater_permitted) begin
          heater_on = 1'b0;
        end
      end
    end
    st.undervolt_fault    = uv_flag;
    st.overtemp_fault     = ot_flag;
    st.cold_fault         = cold_flag;
    st.heater_drive       = heater_on;
    st.volt_sensor_reinit = !it.volt_valid;
    return st;
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    int       v;
    int       t;
    int       uv;
    int       rv;
    uv = int'(limits.undervolt_mv);
    rv = int'(limits.undervolt_recover_mv);
    if (volt_left == 0) begin
      volt_mode = $urandom_range(3);
      volt_left = $urandom_range(25, 1);
    end
    volt_left--;
    if (temp_left == 0) begin
      temp_mode = $urandom_range(5);
      temp_left = $urandom_range(60, 5);
    end
    temp_left--;
    case (volt_mode)
      0:       v = uv - 1 - int'($urandom_range(200));
      1:       v = rv + int'($urandom_range(200));
      2:       v = uv + int'($urandom_range((rv > uv) ? rv - uv - 1 : 0));
      default: v = int'($urandom_range(32767));
    endcase
    case (temp_mode)
      0:       t = int'($signed(limits.overtemp_limit)) + 1 + int'($urandom_range(200));
      1:       t = int'($signed(limits.overtemp_recover_limit)) - int'($urandom_range(200));
      2:       t = int'($signed(limits.heat_on_limit)) - 1 - int'($urandom_range(200));
      3:       t = int'($signed(limits.heat_off_limit)) + int'($urandom_range(200));
      4:       t = int'($signed(limits.heat_on_limit)) + int'($urandom_range(300)) - 150;
      default: t = int'($urandom_range(65535)) - 32768;
    endcase
    it.volt_sample      = 15'(clamp(v, 0, 32767));
    it.volt_valid       = ($urandom_range(99) < 92);
    it.temp_sample      = 16'(clamp(t, -32768, 32767));
    it.temp_valid       = ($urandom_range(99) < 90);
    it.heater_permitted = ($urandom_range(99) < 70);
    return it;
  endfunction

  function automatic cfg_t rand_cfg(input int mode);
    cfg_t c;
    int   uv;
    int   ot;
    int   on;
    case (mode)
      1: c = {15'd0, 15'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 16'h8000, 16'h8000};
      3: c = {15'h7FFF, 15'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF};
      4: c = 126'({$urandom, $urandom, $urandom, $urandom});
      default: begin
        uv = int'($urandom_range(3400, 2800));
        ot = 3000 + int'($urandom_range(2000));
        on = int'($urandom_range(1000)) - 500;
        c.undervolt_mv            = 15'(uv);
        c.undervolt_recover_mv    = 15'(uv + int'($urandom_range(400)));
        c.undervolt_recover_ticks = 16'($urandom_range(20));
        c.overtemp_limit          = 16'(ot);
        c.overtemp_recover_limit  = 16'(ot - int'($urandom_range(1000)));
        c.overtemp_recover_ticks  = 16'($urandom_range(60));
        c.heat_on_limit           = 16'(on);
        c.heat_off_limit          = (mode == 2) ? 16'(on - 1 - int'($urandom_range(500)))
                                                : 16'(on + int'($urandom_range(800)));
      end
    endcase
    return c;
  endfunction

  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t st;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    st = next_status(it);
    pending_status.push_back(typed ? want : st);
  endtask

  // hold the sender until every pending status has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    logic [31:0] mask;
    mask = (r == REG_UV_MV || r == REG_UV_RECOVER_MV) ? 32'h7FFF : 32'hFFFF;
    case (r)
      REG_UV_MV:            limits.undervolt_mv            = v[14:0];
      REG_UV_RECOVER_MV:    limits.undervolt_recover_mv    = v[14:0];
      REG_UV_RECOVER_TICKS: limits.undervolt_recover_ticks = v[15:0];
      REG_OT_LIMIT:         limits.overtemp_limit          = v[15:0];
      REG_OT_RECOVER_LIMIT: limits.overtemp_recover_limit  = v[15:0];
      REG_OT_RECOVER_TICKS: limits.overtemp_recover_ticks  = v[15:0];
      REG_HEAT_ON_LIMIT:    limits.heat_on_limit           = v[15:0];
      REG_HEAT_OFF_LIMIT:   limits.heat_off_limit          = v[15:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (v & mask))
      report_mismatch("register readback", v & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_write(REG_UV_MV,            {17'h0, c.undervolt_mv});
    cfg_write(REG_UV_RECOVER_MV,    {17'h0, c.undervolt_recover_mv});
    cfg_write(REG_UV_RECOVER_TICKS, {16'h0, c.undervolt_recover_ticks});
    cfg_write(REG_OT_LIMIT,         {16'h0, c.overtemp_limit});
    cfg_write(REG_OT_RECOVER_LIMIT, {16'h0, c.overtemp_recover_limit});
    cfg_write(REG_OT_RECOVER_TICKS, {16'h0, c.overtemp_recover_ticks});
    cfg_write(REG_HEAT_ON_LIMIT,    {16'h0, c.heat_on_limit});
    cfg_write(REG_HEAT_OFF_LIMIT,   {16'h0, c.heat_off_limit});
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0)
        report_mismatch("status with nothing pending", 32'h0, 32'(out_data));
      else if (out_data !== pending_status[0])
        report_mismatch("status", 32'(pending_status.pop_front()), 32'(out_data));
      else
        void'(pending_status.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[battery_fault_supervisor] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t dir_cfg;
    int   ph;
    int   k;
    int   n;
    limits = {15'd3300, 15'd3500, 16'd10, 16'd4500, 16'd4000, 16'd60, 16'd0, 16'd500};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (n = 0; n < DIR_SPLIT; n++)
      send_tick(dir_rows[n].tick, dir_rows[n].chk, dir_rows[n].want);
    settle();
    // zero recovery times and crossed heat limits
    dir_cfg = limits;
    dir_cfg.undervolt_recover_ticks = '0;
    dir_cfg.overtemp_recover_ticks  = '0;
    dir_cfg.heat_on_limit           = 16'sd1000;
    dir_cfg.heat_off_limit          = -16'sd1000;
    apply_config(dir_cfg);
    for (n = DIR_SPLIT; n < DIR_ROWS; n++)
      send_tick(dir_rows[n].tick, dir_rows[n].chk, dir_rows[n].want);
    for (ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 35 : (ph == 1) ? 49 : 0;
      rcv_idle = (ph == 0) ? 49 : (ph == 1) ? 35 : 0;
      for (k = 0; k < CHUNKS; k++) begin
        settle();
        apply_config(rand_cfg(k));
        for (n = 0; n < CHUNK_TICKS; n++)
          send_tick(random_tick(), 1'b0, '0);
      end
    end
    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0)
      $display("[battery_fault_supervisor] OK");
    else
      $display("[battery_fault_supervisor] ERROR");
    $finish;
  end

endmodule
